// ===== hdl/vapb_pkg.sv =====
// Shared widths, register indexes and payload types of the position blend unit.
package vapb_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;

   localparam int POS_W    = 32;
   localparam int DIFF_W   = POS_W + 1;
   localparam int MAG_W    = POS_W;
   localparam int SQ_W     = 2 * MAG_W;
   localparam int RAD_W    = SQ_W + 2;
   localparam int LEN_W    = RAD_W / 2;
   localparam int SQRT_STEPS = 3;
   localparam int BASE_W   = 18;
   localparam int GAIN_W   = 32;
   localparam int WEIGHT_W = 17;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_ALPHA    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_VELOCITY_GAIN = 1'b1;

   typedef logic signed [POS_W-1:0]  pos_type;
   typedef logic signed [DIFF_W-1:0] diff_type;

   typedef struct packed {
      pos_type cur_x;
      pos_type cur_y;
      pos_type cur_z;
      pos_type old_x;
      pos_type old_y;
      pos_type old_z;
      logic    frame_end_in;
   } req_payload_type;

   typedef struct packed {
      pos_type               blend_x;
      pos_type               blend_y;
      pos_type               blend_z;
      logic [WEIGHT_W-1:0]   weight;
      logic                  frame_end_out;
   } rsp_payload_type;

   // values that ride along with an entity while its length is worked out
   typedef struct packed {
      pos_type  [2:0] cur;
      diff_type [2:0] d;
      logic           frame_end;
   } side_type;

endpackage

// ===== hdl/vapb_stream_if.sv =====
// Valid/ready stream channel carrying one payload per request.
interface vapb_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/velocity_adaptive_position_blend_unit.sv =====
// Top level: velocity-adaptive blend of current and previous 3-D positions.
//
//   channel   dir  payload
//   req_chan  in   cur_x/y/z, old_x/y/z, frame_end_in
//   rsp_chan  out  blend_x/y/z, weight, frame_end_out
//   csr_*     in   write port: base_alpha (index 0), velocity_gain (index 1)
//
// One request per cycle while the output is not stalled; stages: difference, square, sum, eleven square
// root stages of three root bits each, gain product, term, clamp, blend product, output.
// The whole pipeline advances whenever the output register is empty or being taken;
// a stalled output freezes every stage, so nothing is lost or repeated.
// Reset is synchronous and clears all valid bits and both registers.
module velocity_adaptive_position_blend_unit #(
   parameter int FRAC_BITS = vapb_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   vapb_stream_if.sink                       req_chan,
   vapb_stream_if.source                     rsp_chan,
   input  logic                              csr_wr_en,
   input  logic [vapb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [vapb_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import vapb_pkg::*;

   localparam int AW    = FRAC_BITS + 1;
   localparam int PRODW = LEN_W + GAIN_W;
   localparam int TW    = PRODW + 1;
   localparam int PW    = DIFF_W + AW + 1;
   localparam int QW    = DIFF_W + 1;
   localparam int RW    = POS_W + 3;
   localparam logic [TW-1:0]         ONE_T   = TW'(1) << FRAC_BITS;
   localparam logic [AW-1:0]         ONE_A   = AW'(1) << FRAC_BITS;
   localparam logic [PRODW-1:0]      FMASK   = (PRODW'(1) << FRAC_BITS) - PRODW'(1);
   localparam logic signed [RW-1:0]  POS_MAX = RW'({1'b0, {(POS_W-1){1'b1}}});
   localparam logic signed [RW-1:0]  POS_MIN = -POS_MAX - RW'(1);

   // configuration
   logic signed [BASE_W-1:0] base_ff;
   logic signed [GAIN_W-1:0] gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         gain_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_BASE_ALPHA:    base_ff <= csr_wdata[BASE_W-1:0];
            CSR_VELOCITY_GAIN: gain_ff <= csr_wdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   logic            advance;
   logic            rsp_vld_ff;
   rsp_payload_type rsp_data_ff;

   assign advance        = !rsp_vld_ff || rsp_chan.ready;
   // hold off requests while in reset
   assign req_chan.ready = advance && !reset;
   assign rsp_chan.valid = rsp_vld_ff;
   assign rsp_chan.data  = rsp_data_ff;

   // stage 1: differences
   logic     v1_ff;
   side_type side1_ff;
   side_type side1_in;

   always_comb begin
      side1_in.cur[0]    = req_chan.data.cur_x;
      side1_in.cur[1]    = req_chan.data.cur_y;
      side1_in.cur[2]    = req_chan.data.cur_z;
      side1_in.d[0]      = DIFF_W'(req_chan.data.cur_x) - DIFF_W'(req_chan.data.old_x);
      side1_in.d[1]      = DIFF_W'(req_chan.data.cur_y) - DIFF_W'(req_chan.data.old_y);
      side1_in.d[2]      = DIFF_W'(req_chan.data.cur_z) - DIFF_W'(req_chan.data.old_z);
      side1_in.frame_end = req_chan.data.frame_end_in;
   end

   // stage 2: squares of magnitudes
   logic             v2_ff;
   side_type         side2_ff;
   logic [SQ_W-1:0]  sq2_ff [3];
   logic [SQ_W-1:0]  sq2_in [3];

   always_comb begin
      logic [DIFF_W-1:0] neg;
      logic [MAG_W-1:0]  mag;
      for (int k = 0; k < 3; k++) begin
         neg = -side1_ff.d[k];
         mag = side1_ff.d[k][DIFF_W-1] ? neg[MAG_W-1:0] : side1_ff.d[k][MAG_W-1:0];
         sq2_in[k] = SQ_W'(mag) * SQ_W'(mag);
      end
   end

   // stage 3: sum of squares
   logic              v3_ff;
   side_type          side3_ff;
   logic [RAD_W-1:0]  rad3_ff;
   logic [RAD_W-1:0]  rad3_in;

   assign rad3_in = RAD_W'(sq2_ff[0]) + RAD_W'(sq2_ff[1]) + RAD_W'(sq2_ff[2]);

   logic              vs_out;
   logic [LEN_W-1:0]  len_out;
   side_type          side_out;

   vapb_isqrt #(
      .RAD_W  (RAD_W),
      .STEPS  (SQRT_STEPS),
      .SIDE_W ($bits(side_type))
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (v3_ff),
      .in_rad    (rad3_ff),
      .in_side   (side3_ff),
      .out_valid (vs_out),
      .out_root  (len_out),
      .out_side  (side_out)
   );

   // stage 4: length times gain magnitude
   logic              v4_ff;
   side_type          side4_ff;
   logic [PRODW-1:0]  prod4_ff;
   logic [PRODW-1:0]  prod4_in;
   logic              gneg4_ff;
   logic [GAIN_W-1:0] gmag;

   assign gmag     = gain_ff[GAIN_W-1] ? GAIN_W'(-gain_ff) : gain_ff;
   assign prod4_in = PRODW'(len_out) * PRODW'(gmag);

   // stage 5: signed velocity term, rounded toward minus infinity
   logic                 v5_ff;
   side_type             side5_ff;
   logic signed [TW-1:0] term5_ff;
   logic signed [TW-1:0] term5_in;

   always_comb begin
      logic [PRODW-1:0] tmag;
      tmag = (prod4_ff >> FRAC_BITS) + PRODW'(gneg4_ff && ((prod4_ff & FMASK) != '0));
      term5_in = gneg4_ff ? -$signed(TW'(tmag)) : $signed(TW'(tmag));
   end

   // stage 6: add base and clamp to [0, 1]
   logic           v6_ff;
   side_type       side6_ff;
   logic [AW-1:0]  alpha6_ff;
   logic [AW-1:0]  alpha6_in;

   always_comb begin
      logic signed [TW-1:0] sum;
      sum = TW'(base_ff) + term5_ff;
      if (sum < 0) begin
         alpha6_in = '0;
      end else if (sum > $signed(ONE_T)) begin
         alpha6_in = ONE_A;
      end else begin
         alpha6_in = sum[AW-1:0];
      end
   end

   // stage 7: difference times alpha
   logic                 v7_ff;
   side_type             side7_ff;
   logic [AW-1:0]        alpha7_ff;
   logic signed [PW-1:0] p7_ff [3];
   logic signed [PW-1:0] p7_in [3];

   always_comb begin
      logic signed [PW-1:0] da;
      logic signed [PW-1:0] aa;
      aa = $signed(PW'(alpha6_ff));
      for (int k = 0; k < 3; k++) begin
         da = PW'(side6_ff.d[k]);
         p7_in[k] = da * aa;
      end
   end

   // stage 8: scale, subtract from current, saturate
   rsp_payload_type rsp_data_in;

   always_comb begin
      logic signed [QW-1:0] q;
      logic signed [RW-1:0] r;
      logic signed [POS_W-1:0] res [3];
      for (int k = 0; k < 3; k++) begin
         q = QW'(p7_ff[k] >>> FRAC_BITS);
         r = RW'(side7_ff.cur[k]) - RW'(q);
         if (r > POS_MAX) begin
            res[k] = POS_MAX[POS_W-1:0];
         end else if (r < POS_MIN) begin
            res[k] = POS_MIN[POS_W-1:0];
         end else begin
            res[k] = r[POS_W-1:0];
         end
      end
      rsp_data_in.blend_x       = res[0];
      rsp_data_in.blend_y       = res[1];
      rsp_data_in.blend_z       = res[2];
      rsp_data_in.weight        = WEIGHT_W'(alpha7_ff);
      rsp_data_in.frame_end_out = side7_ff.frame_end;
   end

   // valid bits travel with the data; hold everything while the output stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
         v3_ff      <= 1'b0;
         v4_ff      <= 1'b0;
         v5_ff      <= 1'b0;
         v6_ff      <= 1'b0;
         v7_ff      <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         v1_ff      <= req_chan.valid;
         v2_ff      <= v1_ff;
         v3_ff      <= v2_ff;
         v4_ff      <= vs_out;
         v5_ff      <= v4_ff;
         v6_ff      <= v5_ff;
         v7_ff      <= v6_ff;
         rsp_vld_ff <= v7_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side1_ff    <= side1_in;
         side2_ff    <= side1_ff;
         sq2_ff      <= sq2_in;
         side3_ff    <= side2_ff;
         rad3_ff     <= rad3_in;
         side4_ff    <= side_out;
         prod4_ff    <= prod4_in;
         gneg4_ff    <= gain_ff[GAIN_W-1];
         side5_ff    <= side4_ff;
         term5_ff    <= term5_in;
         side6_ff    <= side5_ff;
         alpha6_ff   <= alpha6_in;
         side7_ff    <= side6_ff;
         alpha7_ff   <= alpha6_ff;
         p7_ff       <= p7_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && !rsp_chan.ready |-> !req_chan.ready)
      else $error("request accepted while output stalled");

   a_alpha_range: assert property (@(posedge clock) disable iff (reset)
      v6_ff |-> alpha6_ff <= ONE_A)
      else $error("clamped alpha above one");

   a_zero_weight: assert property (@(posedge clock) disable iff (reset)
      advance && v7_ff && alpha7_ff == '0 |=>
         rsp_data_ff.blend_x == $past(side7_ff.cur[0]))
      else $error("zero weight did not keep the current position");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> v1_ff)
      else $error("accepted request missing from first stage");

endmodule

// ===== hdl/vapb_isqrt.sv =====
// Pipelined restoring integer square root, a few root digits per stage.
module vapb_isqrt #(
   parameter int RAD_W  = vapb_pkg::RAD_W,
   parameter int STEPS  = vapb_pkg::SQRT_STEPS,
   parameter int SIDE_W = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  logic [RAD_W-1:0]     in_rad,
   input  logic [SIDE_W-1:0]    in_side,
   output logic                 out_valid,
   output logic [RAD_W/2-1:0]   out_root,
   output logic [SIDE_W-1:0]    out_side
);
   import vapb_pkg::*;

   localparam int ROOT_W = RAD_W / 2;
   localparam int NSTAGE = ROOT_W / STEPS;
   localparam int REM_W  = ROOT_W + 3;

   logic [NSTAGE-1:0]  vld_ff;
   logic [RAD_W-1:0]   rad_ff  [NSTAGE];
   logic [ROOT_W-1:0]  root_ff [NSTAGE];
   logic [REM_W-1:0]   rem_ff  [NSTAGE];
   logic [SIDE_W-1:0]  side_ff [NSTAGE];

   for (genvar s = 0; s < NSTAGE; s++) begin : g_stage
      logic               prv_vld;
      logic [RAD_W-1:0]   prv_rad;
      logic [ROOT_W-1:0]  prv_root;
      logic [REM_W-1:0]   prv_rem;
      logic [SIDE_W-1:0]  prv_side;
      logic [RAD_W-1:0]   rad_in;
      logic [ROOT_W-1:0]  root_in;
      logic [REM_W-1:0]   rem_in;

      if (s == 0) begin : g_first
         assign prv_vld  = in_valid;
         assign prv_rad  = in_rad;
         assign prv_root = '0;
         assign prv_rem  = '0;
         assign prv_side = in_side;
      end else begin : g_next
         assign prv_vld  = vld_ff[s-1];
         assign prv_rad  = rad_ff[s-1];
         assign prv_root = root_ff[s-1];
         assign prv_rem  = rem_ff[s-1];
         assign prv_side = side_ff[s-1];
      end

      always_comb begin
         logic [REM_W-1:0] trial;
         rad_in  = prv_rad;
         root_in = prv_root;
         rem_in  = prv_rem;
         for (int j = 0; j < STEPS; j++) begin
            // bring down the next pair of radicand bits
            rem_in = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
            rad_in = rad_in << 2;
            trial  = REM_W'({root_in, 2'b01});
            if (rem_in >= trial) begin
               rem_in  = rem_in - trial;
               root_in = {root_in[ROOT_W-2:0], 1'b1};
            end else begin
               root_in = {root_in[ROOT_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (advance) begin
            vld_ff[s] <= prv_vld;
         end
         if (advance) begin
            rad_ff[s]  <= rad_in;
            root_ff[s] <= root_in;
            rem_ff[s]  <= rem_in;
            side_ff[s] <= prv_side;
         end
      end
   end

   assign out_valid = vld_ff[NSTAGE-1];
   assign out_root  = root_ff[NSTAGE-1];
   assign out_side  = side_ff[NSTAGE-1];

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      vld_ff[NSTAGE-1] |->
         rem_ff[NSTAGE-1] <= {root_ff[NSTAGE-1], 1'b0})
      else $error("square root remainder exceeds twice the root");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(vld_ff))
      else $error("square root stages moved during a stall");

   a_enter: assert property (@(posedge clock) disable iff (reset)
      advance && in_valid |=> vld_ff[0])
      else $error("request lost at square root entry");

endmodule
